// ----- rtl/dgs_pkg.sv -----
`default_nettype none

package dgs_pkg;

  typedef enum logic [1:0] {
    OP_ADD_VERTEX = 2'd0,
    OP_ADD_EDGE   = 2'd1,
    OP_HAS_EDGE   = 2'd2,
    OP_OUT_DEGREE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic lookup;   // key compare drives the adjacency read address
    logic capture;  // item accepted, register lookup results
    logic commit;   // apply update and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy; // result register full and not taken this cycle
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/dgs_ram.sv -----
`default_nettype none

module dgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/dgs_ctrl.sv -----
`default_nettype none

module dgs_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire dgs_pkg::sts_t sts_i,
  output dgs_pkg::cmd_t     cmd_o
);

  dgs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dgs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      dgs_pkg::S_IDLE: begin
        cmd_o.lookup = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = dgs_pkg::S_EXEC;
        end
      end
      dgs_pkg::S_EXEC: begin
        // hold the item until the result register can take it
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = dgs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dgs_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == dgs_pkg::S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/dgs_dp.sv -----
`default_nettype none

module dgs_dp #(
  parameter int MAX_V = 16,
  parameter int KEY_W = 32,
  localparam int IDX_W  = $clog2(MAX_V),
  localparam int CNT_W  = $clog2(MAX_V + 1),
  localparam int EDGE_W = $clog2(MAX_V * MAX_V + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dgs_pkg::cmd_t     cmd_i,
  output dgs_pkg::sts_t          sts_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [KEY_W-1:0]  key_a_i,
  input  wire logic [KEY_W-1:0]  key_b_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             status_o,
  output logic                   edge_found_o,
  output logic [CNT_W-1:0]       out_degree_o,
  output logic [CNT_W-1:0]       vertex_total_o,
  output logic [EDGE_W-1:0]      edge_total_o
);

  // key table, each entry compared in place
  logic [KEY_W-1:0] keys_q [MAX_V];
  logic [CNT_W-1:0] vcount_q, vcount_d;
  logic [EDGE_W-1:0] ecount_q, ecount_d;

  // lookup results of the item in flight
  dgs_pkg::opcode_e op_q;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] s_idx_q, t_idx_q;
  logic             s_hit_q, t_hit_q;

  // result register
  logic              out_valid_q;
  dgs_pkg::status_e  status_q, status_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  degree_q, degree_d;
  logic [CNT_W-1:0]  vtot_q;
  logic [EDGE_W-1:0] etot_q;

  // lookup against the ports
  logic [IDX_W-1:0] s_idx, t_idx;
  logic             s_hit, t_hit;

  always_comb begin
    s_idx = '0;
    t_idx = '0;
    s_hit = 1'b0;
    t_hit = 1'b0;
    for (int i = 0; i < MAX_V; i++) begin
      if ((CNT_W'(i) < vcount_q) && (keys_q[i] == key_a_i)) begin
        s_idx = s_idx | IDX_W'(i);
        s_hit = 1'b1;
      end
      if ((CNT_W'(i) < vcount_q) && (keys_q[i] == key_b_i)) begin
        t_idx = t_idx | IDX_W'(i);
        t_hit = 1'b1;
      end
    end
  end

  // adjacency rows
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [MAX_V-1:0] ram_wdata, row;

  assign ram_raddr = cmd_i.lookup ? s_idx : s_idx_q;

  dgs_ram #(
    .WIDTH (MAX_V),
    .DEPTH (MAX_V)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (row)
  );

  logic [CNT_W-1:0] popcnt;
  logic             t_bit, same;
  logic             key_we;

  always_comb begin
    popcnt = '0;
    for (int j = 0; j < MAX_V; j++) begin
      popcnt = popcnt + CNT_W'(row[j]);
    end
  end

  assign t_bit = row[t_idx_q];
  assign same  = (s_idx_q == t_idx_q);

  always_comb begin
    status_d  = dgs_pkg::ST_OK;
    found_d   = 1'b0;
    degree_d  = '0;
    vcount_d  = vcount_q;
    ecount_d  = ecount_q;
    ram_we    = 1'b0;
    ram_waddr = s_idx_q;
    ram_wdata = row;
    key_we    = 1'b0;
    case (op_q)
      dgs_pkg::OP_ADD_VERTEX: begin
        // duplicate wins over full
        if (s_hit_q) begin
          status_d = dgs_pkg::ST_PRESENT;
        end else if (vcount_q == CNT_W'(MAX_V)) begin
          status_d = dgs_pkg::ST_FULL;
        end else begin
          ram_we    = cmd_i.commit;
          ram_waddr = vcount_q[IDX_W-1:0];
          ram_wdata = '0;
          key_we    = cmd_i.commit;
          vcount_d  = vcount_q + CNT_W'(1);
        end
      end
      dgs_pkg::OP_ADD_EDGE: begin
        if (!s_hit_q || !t_hit_q || same) begin
          status_d = dgs_pkg::ST_NOTFOUND;
        end else if (t_bit) begin
          status_d = dgs_pkg::ST_PRESENT;
        end else begin
          ram_we             = cmd_i.commit;
          ram_wdata[t_idx_q] = 1'b1;
          ecount_d           = ecount_q + EDGE_W'(1);
        end
      end
      dgs_pkg::OP_HAS_EDGE: begin
        if (!s_hit_q || !t_hit_q) begin
          status_d = dgs_pkg::ST_NOTFOUND;
        end else begin
          found_d = t_bit;
        end
      end
      dgs_pkg::OP_OUT_DEGREE: begin
        if (!s_hit_q) begin
          status_d = dgs_pkg::ST_NOTFOUND;
        end else begin
          degree_d = popcnt;
        end
      end
      default: begin
        status_d = dgs_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= '0;
      ecount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        vcount_q    <= vcount_d;
        ecount_q    <= ecount_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      keys_q[vcount_q[IDX_W-1:0]] <= key_q;
    end
    if (cmd_i.capture) begin
      op_q    <= dgs_pkg::opcode_e'(opcode_i);
      key_q   <= key_a_i;
      s_idx_q <= s_idx;
      t_idx_q <= t_idx;
      s_hit_q <= s_hit;
      t_hit_q <= t_hit;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      found_q  <= found_d;
      degree_q <= degree_d;
      vtot_q   <= vcount_d;
      etot_q   <= ecount_d;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign edge_found_o   = found_q;
  assign out_degree_o   = degree_q;
  assign vertex_total_o = vtot_q;
  assign edge_total_o   = etot_q;

endmodule

`default_nettype wire

// ----- rtl/directed_graph_store.sv -----
// Result: an accepted request item is captured; its result item is registered in the
//   execute state, later only while the previous result item waits for out_ready_i.
// Flow: one item in flight at a time; the key compare feeds the adjacency RAM read,
//   then the fetched row is tested and written back in the execute state.
// Reset (rst_ni, async, active low) clears the vertex and edge counts and handshake state.
// No clearing pass: an adjacency row is zeroed when its vertex is added.
`default_nettype none

module directed_graph_store #(
  parameter int MAX_VERTICES = 16,
  parameter int KEY_WIDTH    = 32,
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1),
  localparam int EDGE_W = $clog2(MAX_VERTICES * MAX_VERTICES + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [KEY_WIDTH-1:0] key_a_i,
  input  wire logic [KEY_WIDTH-1:0] key_b_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [1:0]                status_o,
  output logic                      edge_found_o,
  output logic [CNT_W-1:0]          out_degree_o,
  output logic [CNT_W-1:0]          vertex_total_o,
  output logic [EDGE_W-1:0]         edge_total_o
);

  dgs_pkg::cmd_t cmd;
  dgs_pkg::sts_t sts;

  dgs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dgs_dp #(
    .MAX_V (MAX_VERTICES),
    .KEY_W (KEY_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (opcode_i),
    .key_a_i        (key_a_i),
    .key_b_i        (key_b_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .edge_found_o   (edge_found_o),
    .out_degree_o   (out_degree_o),
    .vertex_total_o (vertex_total_o),
    .edge_total_o   (edge_total_o)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item accepted while one is in flight");

  a_vtot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (vertex_total_o <= CNT_W'(MAX_VERTICES)))
    else $error("vertex total beyond table size");

  a_degree_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_degree_o != '0)) |-> (status_o == dgs_pkg::ST_OK))
    else $error("out degree reported on a failed item");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && edge_found_o) |-> (status_o == dgs_pkg::ST_OK))
    else $error("edge found reported on a failed item");
`endif

endmodule

`default_nettype wire

// ----- verif/dgs_checker.sv -----
module dgs_checker #(
  parameter int MAX_VERTICES = 16,
  parameter int KEY_WIDTH    = 32,
  parameter int CNT_W        = 5,
  parameter int EDGE_W       = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [1:0]           opcode_i,
  input  logic [KEY_WIDTH-1:0] key_a_i,
  input  logic [KEY_WIDTH-1:0] key_b_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           status_i,
  input  logic                 edge_found_i,
  input  logic [CNT_W-1:0]     out_degree_i,
  input  logic [CNT_W-1:0]     vertex_total_i,
  input  logic [EDGE_W-1:0]    edge_total_i,
  output int                   mismatches_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    dgs_pkg::status_e    status;
    logic                edge_found;
    logic [CNT_W-1:0]    degree;
    logic [CNT_W-1:0]    vertices;
    logic [EDGE_W-1:0]   edges;
  } graph_result_t;

  logic [KEY_WIDTH-1:0]    key_table [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rows  [MAX_VERTICES];
  int unsigned             vertex_cnt;
  int unsigned             edge_cnt;
  graph_result_t           expected_q [$];

  // only slots below the vertex count hold keys
  function automatic int slot_of(logic [KEY_WIDTH-1:0] key);
    for (int i = 0; i < int'(vertex_cnt); i++) begin
      if (key_table[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic graph_result_t apply_request(dgs_pkg::opcode_e op,
                                                  logic [KEY_WIDTH-1:0] ka,
                                                  logic [KEY_WIDTH-1:0] kb);
    graph_result_t r;
    int src;
    int dst;
    r = '0;
    r.status = dgs_pkg::ST_OK;
    case (op)
      dgs_pkg::OP_ADD_VERTEX: begin
        // duplicate takes precedence over full
        if (slot_of(ka) >= 0) begin
          r.status = dgs_pkg::ST_PRESENT;
        end else if (vertex_cnt >= MAX_VERTICES) begin
          r.status = dgs_pkg::ST_FULL;
        end else begin
          key_table[vertex_cnt] = ka;
          adj_rows[vertex_cnt]  = '0;
          vertex_cnt++;
        end
      end
      dgs_pkg::OP_ADD_EDGE: begin
        src = slot_of(ka);
        dst = slot_of(kb);
        if (src < 0 || dst < 0 || src == dst) begin
          r.status = dgs_pkg::ST_NOTFOUND;
        end else if (adj_rows[src][dst]) begin
          r.status = dgs_pkg::ST_PRESENT;
        end else begin
          adj_rows[src][dst] = 1'b1;
          edge_cnt++;
        end
      end
      dgs_pkg::OP_HAS_EDGE: begin
        src = slot_of(ka);
        dst = slot_of(kb);
        if (src < 0 || dst < 0) begin
          r.status = dgs_pkg::ST_NOTFOUND;
        end else begin
          r.edge_found = adj_rows[src][dst];
        end
      end
      default: begin
        src = slot_of(ka);
        if (src < 0) begin
          r.status = dgs_pkg::ST_NOTFOUND;
        end else begin
          r.degree = CNT_W'($countones(adj_rows[src]));
        end
      end
    endcase
    r.vertices = CNT_W'(vertex_cnt);
    r.edges    = EDGE_W'(edge_cnt);
    return r;
  endfunction

  task automatic report_mismatch(graph_result_t want, graph_result_t got, bit orphan);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      if (orphan) begin
        $display({"%0t: result item with nothing expected: ",
                  "status %0d found %0d degree %0d vertices %0d edges %0d"},
                 $realtime, got.status, got.edge_found, got.degree, got.vertices,
                 got.edges);
      end else begin
        $display({"%0t: result mismatch (exp/got): status %0d/%0d found %0d/%0d ",
                  "degree %0d/%0d vertices %0d/%0d edges %0d/%0d"},
                 $realtime, want.status, got.status, want.edge_found, got.edge_found,
                 want.degree, got.degree, want.vertices, got.vertices, want.edges,
                 got.edges);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    graph_result_t got;
    graph_result_t want;
    if (!rst_ni) begin
      vertex_cnt = 0;
      edge_cnt   = 0;
      for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
      expected_q.delete();
      pending_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{dgs_pkg::status_e'(status_i), edge_found_i, out_degree_i,
                vertex_total_i, edge_total_i};
        if (expected_q.size() == 0) begin
          report_mismatch(got, got, 1'b1);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) report_mismatch(want, got, 1'b0);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(apply_request(dgs_pkg::opcode_e'(opcode_i), key_a_i, key_b_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dgs_pkg::*;

  localparam int NUM_RANDOM = 450;
  localparam int POOL_SIZE  = 20;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode    = OP_ADD_VERTEX;
  logic [31:0] key_a     = '0;
  logic [31:0] key_b     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic        edge_found;
  logic [4:0]  out_degree;
  logic [4:0]  vertex_total;
  logic [8:0]  edge_total;

  int          mismatches;
  int          pending;
  bit          calm = 1'b0;
  logic [31:0] key_pool [POOL_SIZE];

  always #5 clk = ~clk;

  directed_graph_store DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .key_a_i        (key_a),
    .key_b_i        (key_b),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .edge_found_o   (edge_found),
    .out_degree_o   (out_degree),
    .vertex_total_o (vertex_total),
    .edge_total_o   (edge_total)
  );

  dgs_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .opcode_i       (opcode),
    .key_a_i        (key_a),
    .key_b_i        (key_b),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .edge_found_i   (edge_found),
    .out_degree_i   (out_degree),
    .vertex_total_i (vertex_total),
    .edge_total_i   (edge_total),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 88) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic send_request(opcode_e op, logic [31:0] ka, logic [31:0] kb);
    int gap;
    gap = calm ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key_a    <= ka;
    key_b    <= kb;
    do @(posedge clk); while (!in_ready);
  endtask

  // result side back-pressure
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = calm ? 0 : idle_cycles();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int      r;
    opcode_e op;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, duplicates, self-loop, missing keys, degrees
    send_request(OP_OUT_DEGREE, key_pool[0], $urandom);
    send_request(OP_HAS_EDGE,   key_pool[0], key_pool[1]);
    send_request(OP_ADD_VERTEX, key_pool[0], $urandom);
    send_request(OP_ADD_VERTEX, key_pool[1], $urandom);
    send_request(OP_ADD_VERTEX, key_pool[0], $urandom);
    send_request(OP_ADD_EDGE,   key_pool[0], key_pool[1]);
    send_request(OP_ADD_EDGE,   key_pool[0], key_pool[1]);
    send_request(OP_ADD_EDGE,   key_pool[1], key_pool[1]);
    send_request(OP_ADD_EDGE,   key_pool[0], key_pool[2]);
    send_request(OP_ADD_EDGE,   key_pool[2], key_pool[0]);
    send_request(OP_HAS_EDGE,   key_pool[0], key_pool[1]);
    send_request(OP_HAS_EDGE,   key_pool[1], key_pool[0]);
    send_request(OP_HAS_EDGE,   key_pool[0], key_pool[0]);
    send_request(OP_HAS_EDGE,   key_pool[0], key_pool[2]);
    send_request(OP_OUT_DEGREE, key_pool[0], $urandom);
    send_request(OP_OUT_DEGREE, key_pool[2], $urandom);
    send_request(OP_ADD_VERTEX, key_pool[2], $urandom);
    send_request(OP_ADD_EDGE,   key_pool[2], key_pool[0]);
    send_request(OP_ADD_EDGE,   key_pool[2], key_pool[1]);
    send_request(OP_OUT_DEGREE, key_pool[2], $urandom);
    send_request(OP_OUT_DEGREE, key_pool[1], $urandom);

    // random: keys mostly from a pool so the table fills and edges build up
    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm = ((i / 50) % 4) == 3;
      r = $urandom_range(0, 99);
      if (r < 20)      op = OP_ADD_VERTEX;
      else if (r < 55) op = OP_ADD_EDGE;
      else if (r < 80) op = OP_HAS_EDGE;
      else             op = OP_OUT_DEGREE;
      send_request(op, pick_key(), pick_key());
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[directed_graph_store] OK");
    end else begin
      $display("[directed_graph_store] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[directed_graph_store] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dgs_pkg.sv
rtl/dgs_ram.sv
rtl/dgs_ctrl.sv
rtl/dgs_dp.sv
rtl/directed_graph_store.sv
verif/dgs_checker.sv
verif/testbench.sv
